// ===== design/shh2d_pkg.sv =====
// Package: shared types, constants and field widths of the split height histogram.
`timescale 1ns / 1ps
`default_nettype none
package shh2d_pkg;
    localparam int MaxXBins = 64;
    localparam int MaxYBins = 64;
    localparam int XIdxW = $clog2(MaxXBins);
    localparam int YIdxW = $clog2(MaxYBins);
    localparam int AddrW = XIdxW + YIdxW;
    localparam int NumBins = MaxXBins * MaxYBins;
    localparam int CntW = 24;
    localparam int SumW = 40;
    localparam int TotW = 32;
    localparam int BcW = 7;

    typedef enum logic [2:0] {
        REG_X_MIN = 3'd0, REG_X_MAX = 3'd1, REG_Y_MIN = 3'd2,
        REG_Y_MAX = 3'd3, REG_X_BINS = 3'd4, REG_Y_BINS = 3'd5
    } reg_idx_t;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Item passed from front end to back end.
    typedef struct packed {
        logic               is_read;
        logic               in_range;   // read index inside store
        logic [AddrW-1:0]   addr;
        logic [XIdxW-1:0]   bx;
        logic [YIdxW-1:0]   by;
        logic signed [15:0] height;
    } cmd_t;
endpackage
`default_nettype wire

// ===== design/shh2d_front.sv =====
// Front end: window test and bin index computation, bit-serial division per axis.
`timescale 1ns / 1ps
`default_nettype none
module shh2d_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_action,
    input  wire logic signed [15:0]      s_x_offset,
    input  wire logic signed [15:0]      s_y_offset,
    input  wire logic signed [15:0]      s_height_diff,
    input  wire logic [5:0]              s_read_x_bin,
    input  wire logic [5:0]              s_read_y_bin,
    input  wire logic signed [15:0]      x_min,
    input  wire logic signed [15:0]      x_max,
    input  wire logic signed [15:0]      y_min,
    input  wire logic signed [15:0]      y_max,
    input  wire logic [shh2d_pkg::BcW-1:0] x_bins,
    input  wire logic [shh2d_pkg::BcW-1:0] y_bins,
    output logic                         q_valid,
    input  wire logic                    q_ready,
    output shh2d_pkg::cmd_t              q_cmd
);
    // off*bins < 2^17 * 2^9; quotient < 2^9. Divide 26-bit numerator by 17-bit span.
    localparam int NumW = 26;
    localparam int DenW = 17;
    localparam int QW = 9;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001, ST_DIV = 3'b010, ST_OUT = 3'b100
    } st_t;

    st_t st_reg, st_next;
    logic [4:0] step_reg;
    logic [NumW-1:0] xr_reg, yr_reg;       // numerator/quotient shift regs
    logic [DenW-1:0] xd_reg, yd_reg;
    shh2d_pkg::cmd_t cmd_reg;

    function automatic logic [QW-1:0] eff(input logic [shh2d_pkg::BcW-1:0] n,
                                          input int lim);
        logic [QW-1:0] r;
        r = {{(QW-shh2d_pkg::BcW){1'b0}}, n};
        if (n == '0) r = QW'(1);
        if (r > QW'(lim)) r = QW'(lim);
        return r;
    endfunction

    logic x_in, y_in;
    logic [DenW-1:0] xspan, yspan, xoff, yoff;
    logic [QW-1:0] xb, yb;
    assign x_in = (s_x_offset > x_min) && (s_x_offset < x_max);
    assign y_in = (s_y_offset > y_min) && (s_y_offset < y_max);
    assign xspan = DenW'({x_max[15], x_max} - {x_min[15], x_min});
    assign yspan = DenW'({y_max[15], y_max} - {y_min[15], y_min});
    assign xoff = DenW'({s_x_offset[15], s_x_offset} - {x_min[15], x_min});
    assign yoff = DenW'({s_y_offset[15], s_y_offset} - {y_min[15], y_min});
    assign xb = eff(x_bins, shh2d_pkg::MaxXBins);
    assign yb = eff(y_bins, shh2d_pkg::MaxYBins);

    // Bit-serial division: numerator and quotient share one word; the remainder has its own register.
    logic [DenW:0] xrem_reg, yrem_reg, xrs, yrs;
    assign xrs = {xrem_reg[DenW-1:0], xr_reg[NumW-1]};
    assign yrs = {yrem_reg[DenW-1:0], yr_reg[NumW-1]};
    logic xge, yge;
    assign xge = xrs >= {1'b0, xd_reg};
    assign yge = yrs >= {1'b0, yd_reg};

    assign s_ready = (st_reg == ST_IDLE);
    assign q_valid = (st_reg == ST_OUT);
    assign q_cmd = cmd_reg;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (s_valid) begin
                if (s_action == shh2d_pkg::ACT_READ) st_next = ST_OUT;
                else if (x_in && y_in) st_next = ST_DIV;
            end
            ST_DIV: if (step_reg == 5'(NumW - 1)) st_next = ST_OUT;
            ST_OUT: if (q_ready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= ST_IDLE;
        else st_reg <= st_next;
        unique case (st_reg)
            ST_IDLE: begin
                step_reg <= '0;
                xrem_reg <= '0;
                yrem_reg <= '0;
                xr_reg <= NumW'(xoff) * NumW'(xb);
                yr_reg <= NumW'(yoff) * NumW'(yb);
                xd_reg <= xspan;
                yd_reg <= yspan;
                cmd_reg.is_read <= s_action;
                cmd_reg.in_range <= 1'b1;
                cmd_reg.height <= s_height_diff;
                cmd_reg.bx <= s_read_x_bin[shh2d_pkg::XIdxW-1:0];
                cmd_reg.by <= s_read_y_bin[shh2d_pkg::YIdxW-1:0];
                cmd_reg.addr <= {s_read_x_bin[shh2d_pkg::XIdxW-1:0],
                                 s_read_y_bin[shh2d_pkg::YIdxW-1:0]};
            end
            ST_DIV: begin
                step_reg <= step_reg + 5'd1;
                xr_reg <= {xr_reg[NumW-2:0], xge};
                yr_reg <= {yr_reg[NumW-2:0], yge};
                xrem_reg <= xge ? xrs - {1'b0, xd_reg} : xrs;
                yrem_reg <= yge ? yrs - {1'b0, yd_reg} : yrs;
                if (step_reg == 5'(NumW - 1)) begin
                    cmd_reg.bx <= shh2d_pkg::XIdxW'({xr_reg[QW-2:0], xge});
                    cmd_reg.by <= shh2d_pkg::YIdxW'({yr_reg[QW-2:0], yge});
                    cmd_reg.addr <= {shh2d_pkg::XIdxW'({xr_reg[QW-2:0], xge}),
                                     shh2d_pkg::YIdxW'({yr_reg[QW-2:0], yge})};
                    cmd_reg.in_range <= ({xr_reg[QW-2:0], xge} < QW'(shh2d_pkg::MaxXBins))
                        && ({yr_reg[QW-2:0], yge} < QW'(shh2d_pkg::MaxYBins));
                end
            end
            default: ;
        endcase
    end

    ap_busy: assert property (@(posedge aclk) disable iff (!aresetn) !(q_valid && s_ready))
        else $error("front busy overlap");
    ap_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(st_reg))
        else $error("state not one-hot");
    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_ready |=> q_valid && $stable(q_cmd))
        else $error("queue entry changed while stalled");
    ap_div: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_DIV |-> !s_ready)
        else $error("ready during divide");
endmodule
`default_nettype wire

// ===== design/shh2d_queue.sv =====
// Two-entry queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module shh2d_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire shh2d_pkg::cmd_t in_cmd,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output shh2d_pkg::cmd_t      out_cmd
);
    shh2d_pkg::cmd_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;
    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) mem_reg[wp_reg] <= in_cmd;
    end
    ap_cnt: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count overflow");
    ap_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers inconsistent");
    ap_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd1 |-> wp_reg != rp_reg)
        else $error("queue pointers inconsistent");
endmodule
`default_nettype wire

// ===== design/shh2d_back.sv =====
// Back end: bin memory update, clearing sweep, mean division and result register.
`timescale 1ns / 1ps
`default_nettype none
module shh2d_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire shh2d_pkg::cmd_t q_cmd,
    output logic                 clearing,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [5:0]           m_bin_x,
    output logic [5:0]           m_bin_y,
    output logic [14:0]          m_upper_mean,
    output logic signed [15:0]   m_lower_mean,
    output logic [15:0]          m_width_sum,
    output logic [31:0]          m_total_samples
);
    localparam int AW = shh2d_pkg::AddrW;
    localparam int CW = shh2d_pkg::CntW;
    localparam int SW = shh2d_pkg::SumW;
    localparam int EW = 2 * CW + 2 * SW;
    localparam int DivSteps = SW;

    typedef enum logic [6:0] {
        ST_CLR = 7'b0000001, ST_IDLE = 7'b0000010, ST_RD = 7'b0000100,
        ST_UPD = 7'b0001000, ST_DIVU = 7'b0010000, ST_DIVL = 7'b0100000,
        ST_OUT = 7'b1000000
    } st_t;

    // One memory word holds both counts and both sums of a bin.
    logic [EW-1:0] mem [shh2d_pkg::NumBins];
    logic [EW-1:0] rdata_reg;
    logic [AW-1:0] addr_reg, clr_reg;
    st_t st_reg, st_next;
    shh2d_pkg::cmd_t cmd_reg;
    logic [shh2d_pkg::TotW-1:0] total_reg;
    logic [5:0] step_reg;
    logic [SW-1:0] num_reg;
    logic [CW:0] rem_reg;
    logic [CW-1:0] den_reg;
    logic [SW-1:0] up_reg;
    logic [SW-1:0] lo_reg;

    logic [CW-1:0] uc, lc;
    logic signed [SW-1:0] us, ls;
    assign {uc, lc, us, ls} = rdata_reg;

    logic we;
    logic [EW-1:0] wdata;
    logic [AW-1:0] waddr;
    logic pos, full;
    assign pos = cmd_reg.height > 16'sd0;
    assign full = pos ? (uc == {CW{1'b1}}) : (lc == {CW{1'b1}});

    always_comb begin
        we = 1'b0;
        waddr = addr_reg;
        wdata = rdata_reg;
        if (st_reg == ST_CLR) begin
            we = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end else if (st_reg == ST_UPD && !full) begin
            we = 1'b1;
            if (pos) wdata = {uc + CW'(1), lc, us + SW'(cmd_reg.height), ls};
            else wdata = {uc, lc + CW'(1), us, ls + SW'(cmd_reg.height)};
        end
    end

    // Capture the bin word in every idle cycle, so a taken beat's word is held for the whole item.
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (st_reg == ST_IDLE) rdata_reg <= mem[q_cmd.addr];
    end

    logic [CW:0] rs;
    logic ge;
    assign rs = {rem_reg[CW-1:0], num_reg[SW-1]};
    assign ge = rs >= {1'b0, den_reg};
    logic [SW-1:0] lmag;
    assign lmag = SW'(-ls);

    assign q_ready = (st_reg == ST_IDLE);
    assign clearing = (st_reg == ST_CLR);
    assign m_valid = (st_reg == ST_OUT);

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLR:  if (clr_reg == AW'(shh2d_pkg::NumBins - 1)) st_next = ST_IDLE;
            ST_IDLE: if (q_valid) st_next = ST_RD;
            ST_RD:   st_next = cmd_reg.is_read ? ST_DIVU : ST_UPD;
            ST_UPD:  st_next = ST_IDLE;
            ST_DIVU: if (step_reg == 6'(DivSteps - 1)) st_next = ST_DIVL;
            ST_DIVL: if (step_reg == 6'(DivSteps - 1)) st_next = ST_OUT;
            ST_OUT:  if (m_ready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    logic [SW-1:0] up_c, lo_c, wsum;
    always_comb begin
        up_c = (!cmd_reg.in_range || uc == '0) ? '0 : up_reg;
        lo_c = (!cmd_reg.in_range || lc == '0) ? '0 : lo_reg;
        if (up_c > SW'(32767)) up_c = SW'(32767);
        if (lo_c > SW'(32768)) lo_c = SW'(32768);
        wsum = up_c + lo_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLR;
            clr_reg <= '0;
            total_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_CLR) clr_reg <= clr_reg + AW'(1);
            if (st_reg == ST_UPD && !full && total_reg != '1)
                total_reg <= total_reg + 32'd1;
        end
        unique case (st_reg)
            ST_IDLE: begin
                cmd_reg <= q_cmd;
                addr_reg <= q_cmd.addr;
            end
            ST_RD: begin
                step_reg <= '0;
                rem_reg <= '0;
                num_reg <= us;
                den_reg <= uc;
            end
            ST_DIVU: begin
                // Last upper step: store the quotient and load the lower division.
                if (step_reg == 6'(DivSteps - 1)) begin
                    up_reg <= {num_reg[SW-2:0], ge};
                    step_reg <= '0;
                    rem_reg <= '0;
                    num_reg <= lmag;
                    den_reg <= lc;
                end else begin
                    step_reg <= step_reg + 6'd1;
                    num_reg <= {num_reg[SW-2:0], ge};
                    rem_reg <= ge ? rs - {1'b0, den_reg} : rs;
                end
            end
            ST_DIVL: begin
                step_reg <= step_reg + 6'd1;
                num_reg <= {num_reg[SW-2:0], ge};
                rem_reg <= ge ? rs - {1'b0, den_reg} : rs;
                if (step_reg == 6'(DivSteps - 1)) lo_reg <= {num_reg[SW-2:0], ge};
            end
            default: ;
        endcase
        if (st_reg == ST_DIVL && step_reg == 6'(DivSteps - 1)) begin
            m_bin_x <= 6'(cmd_reg.bx);
            m_bin_y <= 6'(cmd_reg.by);
        end
    end

    // Result fields follow the registered quotients once division ends.
    assign m_upper_mean = up_c[14:0];
    assign m_lower_mean = 16'(-lo_c);
    assign m_width_sum = wsum[15:0];
    assign m_total_samples = total_reg;

    ap_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(st_reg))
        else $error("state not one-hot");
    ap_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !q_ready && !m_valid)
        else $error("work during clearing sweep");
    ap_tot: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != ST_UPD |=> $stable(total_reg))
        else $error("total moved outside update");
endmodule
`default_nettype wire

// ===== design/split_height_histogram_2d_top.sv =====
// Top level: configuration registers and the front, queue and back end of the histogram.
//
// Usage:
//   Input channel s_*: one beat is an add item (s_action 0) or a read item (1).
//   An add beat lands in one bin when both offsets sit strictly inside the
//   window; it yields no result. A read beat yields one m_* result beat.
//   Configuration channel cfg_*: index selects x_min, x_max, y_min, y_max,
//   x_bin_count, y_bin_count in that order; other indexes are ignored.
// Timing:
//   Front end passes a read straight to its output register; an in-window add
//   first runs a 26-step serial bin division on both axes at once; an add
//   outside the window is dropped and never reaches the queue. Back end
//   handles an add as memory read, modify, write, and a read as two 40-step
//   serial mean divisions (upper, then lower) before its result beat.
//   A two-entry queue lets both ends stall on their own.
// Reset:
//   aresetn low for one cycle clears control and loads register defaults; the
//   back end then sweeps all 4096 bins of the bin memory, one bin per cycle,
//   while s_ready stays low. cfg writes are taken throughout.
// Stall: a result held on m_* by low m_ready holds the back end; the front end
//   and queue keep accepting beats until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module split_height_histogram_2d_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic signed [15:0] s_x_offset,
    input  wire logic signed [15:0] s_y_offset,
    input  wire logic signed [15:0] s_height_diff,
    input  wire logic [5:0]         s_read_x_bin,
    input  wire logic [5:0]         s_read_y_bin,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [5:0]              m_bin_x,
    output logic [5:0]              m_bin_y,
    output logic [14:0]             m_upper_mean,
    output logic signed [15:0]      m_lower_mean,
    output logic [15:0]             m_width_sum,
    output logic [31:0]             m_total_samples
);
    logic signed [15:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [shh2d_pkg::BcW-1:0] x_bins_reg, y_bins_reg;

    assign cfg_ready = 1'b1;

    // Hold register values; update only the addressed one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg <= -16'sd2560;
            x_max_reg <= 16'sd2560;
            y_min_reg <= -16'sd2560;
            y_max_reg <= 16'sd2560;
            x_bins_reg <= 7'd40;
            y_bins_reg <= 7'd40;
        end else if (cfg_valid) begin
            case (cfg_index)
                shh2d_pkg::REG_X_MIN:  x_min_reg <= cfg_data;
                shh2d_pkg::REG_X_MAX:  x_max_reg <= cfg_data;
                shh2d_pkg::REG_Y_MIN:  y_min_reg <= cfg_data;
                shh2d_pkg::REG_Y_MAX:  y_max_reg <= cfg_data;
                shh2d_pkg::REG_X_BINS: x_bins_reg <= cfg_data[shh2d_pkg::BcW-1:0];
                shh2d_pkg::REG_Y_BINS: y_bins_reg <= cfg_data[shh2d_pkg::BcW-1:0];
                default: ;
            endcase
        end
    end

    logic f_ready, f_valid, q_in_ready, b_valid, b_ready, clearing;
    shh2d_pkg::cmd_t f_cmd, b_cmd;

    // Drop input ready during the clearing sweep.
    assign s_ready = f_ready && !clearing;

    shh2d_front u_front (
        .aclk, .aresetn,
        .s_valid(s_valid && !clearing), .s_ready(f_ready),
        .s_action, .s_x_offset, .s_y_offset, .s_height_diff,
        .s_read_x_bin, .s_read_y_bin,
        .x_min(x_min_reg), .x_max(x_max_reg), .y_min(y_min_reg), .y_max(y_max_reg),
        .x_bins(x_bins_reg), .y_bins(y_bins_reg),
        .q_valid(f_valid), .q_ready(q_in_ready), .q_cmd(f_cmd)
    );

    shh2d_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(q_in_ready), .in_cmd(f_cmd),
        .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
    );

    shh2d_back u_back (
        .aclk, .aresetn,
        .q_valid(b_valid), .q_ready(b_ready), .q_cmd(b_cmd),
        .clearing,
        .m_valid, .m_ready, .m_bin_x, .m_bin_y, .m_upper_mean,
        .m_lower_mean, .m_width_sum, .m_total_samples
    );

    ap_clr: assert property (@(posedge aclk) disable iff (!aresetn) clearing |-> !s_ready)
        else $error("input taken during clear");
    ap_win: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(cfg_valid) && $past(cfg_index) == shh2d_pkg::REG_X_MIN
        |-> x_min_reg == $past(cfg_data))
        else $error("x_min write lost");
    ap_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_valid |=> $stable(x_bins_reg) && $stable(y_bins_reg))
        else $error("bin count moved without write");
endmodule
`default_nettype wire

// ===== sim/tb_split_height_histogram_2d_top.sv =====
// Testbench: random and directed add/read beats against a bin-store predictor of the histogram.
`timescale 1ns / 1ps
`default_nettype none
module tb_split_height_histogram_2d_top;

    // One input beat of the sample channel.
    typedef struct {
        logic              act;
        logic signed [15:0] xo;
        logic signed [15:0] yo;
        logic signed [15:0] hd;
        logic [5:0]        rx;
        logic [5:0]        ry;
    } sample_beat_t;

    // One expected result beat.
    typedef struct {
        logic [5:0]  bx;
        logic [5:0]  by;
        logic [14:0] up;
        logic [15:0] lo;
        logic [15:0] ws;
        logic [31:0] tot;
    } bin_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = 1'b0;
    logic signed [15:0] s_x_offset = '0;
    logic signed [15:0] s_y_offset = '0;
    logic signed [15:0] s_height_diff = '0;
    logic [5:0] s_read_x_bin = '0;
    logic [5:0] s_read_y_bin = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [5:0] m_bin_x;
    logic [5:0] m_bin_y;
    logic [14:0] m_upper_mean;
    logic signed [15:0] m_lower_mean;
    logic [15:0] m_width_sum;
    logic [31:0] m_total_samples;

    split_height_histogram_2d_top i_dut (.*);

    // Predictor state: window, bin counts and the bin store.
    logic signed [15:0] win_x_lo, win_x_hi, win_y_lo, win_y_hi;
    logic [6:0] nbins_x, nbins_y;
    logic [23:0] up_cnt [shh2d_pkg::NumBins];
    logic [23:0] lo_cnt [shh2d_pkg::NumBins];
    longint up_sum [shh2d_pkg::NumBins];
    longint lo_sum [shh2d_pkg::NumBins];
    logic [31:0] accepted_total;

    sample_beat_t pending_beats[$];
    bin_report_t  expected_reports[$];
    int errors = 0;
    int n_adds = 0;
    int n_reads = 0;
    int n_results = 0;
    int idle_in_pct = 0;
    int idle_out_pct = 0;
    int stall_cycles = 0;
    bit s_taken = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Pick the bin on one axis; return -1 when outside the open window.
    function automatic int axis_bin(logic signed [15:0] v, logic signed [15:0] lo,
                                    logic signed [15:0] hi, logic [6:0] reg_n, int lim);
        longint span, off;
        int n;
        n = (reg_n == 0) ? 1 : ((reg_n > lim) ? lim : int'(reg_n));
        if (!(v > lo && v < hi)) return -1;
        span = longint'(hi) - longint'(lo);
        off = longint'(v) - longint'(lo);
        return int'((off * n) / span);
    endfunction

    // Update the bin store for an add beat, or return the report of a read beat.
    function automatic bit bin_store_step(sample_beat_t b, output bin_report_t r);
        int ix, iy, a;
        longint um, lm;
        r = '{default: '0};
        if (b.act == shh2d_pkg::ACT_ADD) begin
            ix = axis_bin(b.xo, win_x_lo, win_x_hi, nbins_x, shh2d_pkg::MaxXBins);
            iy = axis_bin(b.yo, win_y_lo, win_y_hi, nbins_y, shh2d_pkg::MaxYBins);
            if (ix < 0 || iy < 0) return 1'b0;
            a = ix * shh2d_pkg::MaxYBins + iy;
            if (b.hd > 0) begin
                if (up_cnt[a] == 24'hFFFFFF) return 1'b0;
                up_cnt[a]++;
                up_sum[a] += longint'(b.hd);
            end else begin
                if (lo_cnt[a] == 24'hFFFFFF) return 1'b0;
                lo_cnt[a]++;
                lo_sum[a] += longint'(b.hd);
            end
            if (accepted_total != 32'hFFFFFFFF) accepted_total++;
            return 1'b0;
        end
        um = 0;
        lm = 0;
        a = int'(b.rx) * shh2d_pkg::MaxYBins + int'(b.ry);
        if (up_cnt[a] != 0) um = up_sum[a] / longint'(up_cnt[a]);
        if (lo_cnt[a] != 0) lm = (-lo_sum[a]) / longint'(lo_cnt[a]);
        if (um > 32767) um = 32767;
        if (lm > 32768) lm = 32768;
        r.bx = b.rx;
        r.by = b.ry;
        r.up = um[14:0];
        r.lo = 16'(-lm);
        r.ws = 16'(um + lm);
        r.tot = accepted_total;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Note an input beat taken at the rising edge.
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
    end

    // Driver: push queued beats at the falling edge, predict on acceptance.
    always @(negedge aclk) begin
        bin_report_t rep;
        if (s_taken) begin
            if (bin_store_step(pending_beats.pop_front(), rep)) expected_reports.push_back(rep);
        end
        if (!s_valid || s_taken) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
                s_valid       <= 1'b1;
                s_action      <= pending_beats[0].act;
                s_x_offset    <= pending_beats[0].xo;
                s_y_offset    <= pending_beats[0].yo;
                s_height_diff <= pending_beats[0].hd;
                s_read_x_bin  <= pending_beats[0].rx;
                s_read_y_bin  <= pending_beats[0].ry;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= idle_out_pct);
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge aclk) begin
        bin_report_t e;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected result beat, bin_x", m_bin_x, -1);
            end else begin
                e = expected_reports.pop_front();
                if (m_bin_x !== e.bx) report_mismatch("bin_x", m_bin_x, e.bx);
                if (m_bin_y !== e.by) report_mismatch("bin_y", m_bin_y, e.by);
                if (m_upper_mean !== e.up) report_mismatch("upper_mean", m_upper_mean, e.up);
                if (m_lower_mean !== e.lo)
                    report_mismatch("lower_mean", m_lower_mean, $signed(e.lo));
                if (m_width_sum !== e.ws) report_mismatch("width_sum", m_width_sum, e.ws);
                if (m_total_samples !== e.tot)
                    report_mismatch("total_samples", m_total_samples, e.tot);
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles > 40000) begin
                $display("Watchdog expired, nothing moved");
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Write one register through the config channel and mirror it.
    task automatic write_reg(shh2d_pkg::reg_idx_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            shh2d_pkg::REG_X_MIN:  win_x_lo = val;
            shh2d_pkg::REG_X_MAX:  win_x_hi = val;
            shh2d_pkg::REG_Y_MIN:  win_y_lo = val;
            shh2d_pkg::REG_Y_MAX:  win_y_hi = val;
            shh2d_pkg::REG_X_BINS: nbins_x = val[6:0];
            shh2d_pkg::REG_Y_BINS: nbins_y = val[6:0];
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(logic signed [15:0] xl, logic signed [15:0] xh,
                              logic signed [15:0] yl, logic signed [15:0] yh,
                              logic [6:0] nx, logic [6:0] ny);
        write_reg(shh2d_pkg::REG_X_MIN, xl);
        write_reg(shh2d_pkg::REG_X_MAX, xh);
        write_reg(shh2d_pkg::REG_Y_MIN, yl);
        write_reg(shh2d_pkg::REG_Y_MAX, yh);
        write_reg(shh2d_pkg::REG_X_BINS, {9'd0, nx});
        write_reg(shh2d_pkg::REG_Y_BINS, {9'd0, ny});
    endtask

    // Hold until the driver is empty and every result has come, then let the
    // back end finish a trailing add.
    task automatic drain();
        wait (pending_beats.size() == 0 && !s_valid);
        wait (expected_reports.size() == 0);
        repeat (120) @(posedge aclk);
    endtask

    function automatic void push_add(logic signed [15:0] x, logic signed [15:0] y,
                                     logic signed [15:0] h);
        sample_beat_t b;
        b = '{act: shh2d_pkg::ACT_ADD, xo: x, yo: y, hd: h,
              rx: 6'($urandom), ry: 6'($urandom)};
        pending_beats.push_back(b);
        n_adds++;
    endfunction

    function automatic void push_read(logic [5:0] x, logic [5:0] y);
        sample_beat_t b;
        b = '{act: shh2d_pkg::ACT_READ, xo: 16'($urandom), yo: 16'($urandom),
              hd: 16'($urandom), rx: x, ry: y};
        pending_beats.push_back(b);
        n_reads++;
    endfunction

    // Random phase: mostly in-window adds, with reads of random bins.
    task automatic random_phase(int count);
        logic signed [15:0] x, y, h;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(3) == 0) begin
                push_read(6'($urandom_range(nbins_x > 0 ? nbins_x - 1 : 0)),
                          6'($urandom_range(nbins_y > 0 ? nbins_y - 1 : 0)));
            end else begin
                if ($urandom_range(9) == 0) begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end else begin
                    x = 16'(win_x_lo + 1 + $urandom_range(int'(win_x_hi) - int'(win_x_lo) - 2));
                    y = 16'(win_y_lo + 1 + $urandom_range(int'(win_y_hi) - int'(win_y_lo) - 2));
                end
                case ($urandom_range(3))
                    0: h = 16'($urandom);
                    1: h = 16'($urandom_range(200)) - 16'sd100;
                    2: h = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    default: h = 16'sd0;
                endcase
                push_add(x, y, h);
            end
        end
    endtask

    initial begin
        win_x_lo = -16'sd2560;
        win_x_hi = 16'sd2560;
        win_y_lo = -16'sd2560;
        win_y_hi = 16'sd2560;
        nbins_x = 7'd40;
        nbins_y = 7'd40;
        accepted_total = '0;
        for (int a = 0; a < shh2d_pkg::NumBins; a++) begin
            up_cnt[a] = '0;
            lo_cnt[a] = '0;
            up_sum[a] = 0;
            lo_sum[a] = 0;
        end
        idle_in_pct = 21;
        idle_out_pct = 71;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset window, edges, extreme heights, zero height, reads.
        push_add(-16'sd2560, 16'sd0, 16'sd5);        // on min edge: ignored
        push_add(16'sd2560, 16'sd0, 16'sd5);         // on max edge: ignored
        push_add(-16'sd2559, -16'sd2559, 16'sh7FFF);
        push_add(-16'sd2559, -16'sd2559, 16'sh7FFF);
        push_add(-16'sd2559, -16'sd2559, 16'sh8000);
        push_add(-16'sd2559, -16'sd2559, 16'sd0);
        push_add(16'sd2559, 16'sd2559, 16'sd1);
        push_add(16'sh7FFF, 16'sh8000, 16'sd3);      // far outside
        push_read(6'd0, 6'd0);
        push_read(6'd39, 6'd39);
        push_read(6'd63, 6'd63);
        push_read(6'd20, 6'd5);
        // Hold the sender until the directed results are in.
        drain();

        // Full-range window, bin counts zero and above the maximum.
        set_window(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 7'd0, 7'd127);
        push_add(16'sh8001, 16'sh8001, 16'sd7);
        push_add(16'sh7FFE, 16'sh7FFE, -16'sd7);
        push_add(16'sd0, 16'sh7FFE, 16'sd9);
        push_read(6'd0, 6'd0);
        push_read(6'd0, 6'd63);
        push_read(6'd0, 6'd32);
        // Empty window: max below min on x.
        drain();
        set_window(16'sd100, -16'sd100, -16'sd50, 16'sd50, 7'd64, 7'd1);
        push_add(16'sd0, 16'sd0, 16'sd4);
        push_read(6'd0, 6'd0);
        drain();

        // Random phases over several settings and idle patterns.
        set_window(-16'sd640, 16'sd640, -16'sd320, 16'sd960, 7'd8, 7'd5);
        random_phase(210);
        drain();
        idle_in_pct = 71;
        idle_out_pct = 21;
        set_window(16'sh8000, 16'sh7FFF, -16'sd3, 16'sd3, 7'd64, 7'd64);
        random_phase(210);
        drain();
        idle_in_pct = 0;
        idle_out_pct = 0;
        set_window(-16'sd2560, 16'sd2560, -16'sd2560, 16'sd2560, 7'd40, 7'd40);
        random_phase(210);
        drain();

        $display("Covered %0d adds and %0d reads, %0d results checked, over five settings",
                 n_adds, n_reads, n_results);
        $display("including window edges, empty window and out-of-range bin counts");
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== split_height_histogram_2d_top.f =====
design/shh2d_pkg.sv
design/shh2d_front.sv
design/shh2d_queue.sv
design/shh2d_back.sv
design/split_height_histogram_2d_top.sv
sim/tb_split_height_histogram_2d_top.sv
